### sv/mfd_pkg.sv
`timescale 1ns / 1ps

package mfd_pkg;

   localparam int ByteWidth    = 8;
   localparam int PhaseWidth   = 3;
   localparam int VerdictWidth = 3;
   localparam int CsrIndexWidth = 2;

   localparam logic [ByteWidth-1:0] StartMarkerReset = 8'd170;
   localparam logic [ByteWidth-1:0] EndMarkerReset   = 8'd85;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_START_MARKER = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_END_MARKER   = 2'd1;

   // parser phases
   localparam logic [PhaseWidth-1:0] PH_HUNT    = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_CMD     = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_LEN     = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_PAY     = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_SUM     = 3'd4;
   localparam logic [PhaseWidth-1:0] PH_END_OK  = 3'd5;
   localparam logic [PhaseWidth-1:0] PH_END_BAD = 3'd6;
   localparam logic [PhaseWidth-1:0] PH_DONE    = 3'd7;

   // frame verdicts
   localparam logic [VerdictWidth-1:0] V_OK      = 3'd0;
   localparam logic [VerdictWidth-1:0] V_NOFRAME = 3'd1;
   localparam logic [VerdictWidth-1:0] V_SHORT   = 3'd2;
   localparam logic [VerdictWidth-1:0] V_BADEND  = 3'd3;
   localparam logic [VerdictWidth-1:0] V_BADSUM  = 3'd4;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic [ByteWidth-1:0]  cmd;
      logic [ByteWidth-1:0]  len;
      logic [ByteWidth-1:0]  idx;
      logic [ByteWidth-1:0]  sum;
   } mfd_state_type;

   typedef struct packed {
      logic                    kind;
      logic [ByteWidth-1:0]    pbyte;
      logic [ByteWidth-1:0]    pidx;
      logic [ByteWidth-1:0]    cmd;
      logic [ByteWidth-1:0]    len;
      logic [VerdictWidth-1:0] verdict;
   } mfd_result_type;

endpackage

### sv/mfd_parse.sv
`timescale 1ns / 1ps

module mfd_parse (
   input  mfd_pkg::mfd_state_type  state,
   input  logic [7:0]              rx_byte,
   input  logic                    buffer_end,
   input  logic [7:0]              start_marker,
   input  logic [7:0]              end_marker,
   output mfd_pkg::mfd_state_type  state_in,
   output mfd_pkg::mfd_result_type res,
   output logic                    res_valid
);
   import mfd_pkg::*;

   logic [ByteWidth:0] idx_next;

   assign idx_next = {1'b0, state.idx} + {{ByteWidth{1'b0}}, 1'b1};

   always_comb begin
      state_in  = state;
      res       = '0;
      res_valid = 1'b0;
      case (state.phase)
         PH_HUNT: begin
            if (rx_byte == start_marker && !buffer_end) begin
               state_in.phase = PH_CMD;
            end else if (buffer_end) begin
               res_valid   = 1'b1;
               res.kind    = KIND_VERDICT;
               res.verdict = V_NOFRAME;
            end
         end
         PH_CMD: begin
            state_in.cmd = rx_byte;
            state_in.sum = rx_byte;
            if (buffer_end) begin
               state_in.phase = PH_HUNT;
               res_valid      = 1'b1;
               res.kind       = KIND_VERDICT;
               res.verdict    = V_NOFRAME;
            end else begin
               state_in.phase = PH_LEN;
            end
         end
         PH_LEN: begin
            state_in.len = rx_byte;
            state_in.idx = '0;
            if (buffer_end) begin
               state_in.phase = PH_HUNT;
               res_valid      = 1'b1;
               res.kind       = KIND_VERDICT;
               res.verdict    = V_NOFRAME;
            end else begin
               state_in.phase = (rx_byte != '0) ? PH_PAY : PH_SUM;
            end
         end
         PH_PAY: begin
            res_valid = 1'b1;
            res.cmd   = state.cmd;
            res.len   = state.len;
            if (buffer_end) begin
               state_in.phase = PH_HUNT;
               res.kind       = KIND_VERDICT;
               res.verdict    = V_SHORT;
            end else begin
               res.kind     = KIND_PAYLOAD;
               res.pbyte    = rx_byte;
               res.pidx     = state.idx;
               state_in.sum = state.sum + rx_byte;
               state_in.idx = idx_next[ByteWidth-1:0];
               if (idx_next >= {1'b0, state.len}) begin
                  state_in.phase = PH_SUM;
               end
            end
         end
         PH_SUM: begin
            if (buffer_end) begin
               state_in.phase = PH_HUNT;
               res_valid      = 1'b1;
               res.kind       = KIND_VERDICT;
               res.cmd        = state.cmd;
               res.len        = state.len;
               res.verdict    = V_SHORT;
            end else begin
               state_in.phase = (rx_byte == state.sum) ? PH_END_OK : PH_END_BAD;
            end
         end
         PH_END_OK, PH_END_BAD: begin
            res_valid = 1'b1;
            res.kind  = KIND_VERDICT;
            res.cmd   = state.cmd;
            res.len   = state.len;
            // end marker is judged before the checksum
            if (rx_byte != end_marker) begin
               res.verdict = V_BADEND;
            end else if (state.phase == PH_END_OK) begin
               res.verdict = V_OK;
            end else begin
               res.verdict = V_BADSUM;
            end
            state_in.phase = buffer_end ? PH_HUNT : PH_DONE;
         end
         default: begin
            if (buffer_end) begin
               state_in.phase = PH_HUNT;
            end
         end
      endcase
   end

endmodule

### sv/mfd_out_reg.sv
`timescale 1ns / 1ps

module mfd_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  mfd_pkg::mfd_result_type res,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic                    can_load,
   output mfd_pkg::mfd_result_type rsp_data
);
   import mfd_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   mfd_result_type data_ff;

   assign can_load  = !valid_ff || rsp_ready;
   assign valid_in  = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

endmodule

### sv/marker_frame_deframer_sum8.sv
`timescale 1ns / 1ps

// Marker-framed byte-stream deframer with an 8-bit additive checksum. One
// received byte is taken per transaction on the req_ channel, with
// req_buffer_end high on the last byte of each receive buffer. The parser
// hunts for the start marker, then reads command, length, that many payload
// bytes, a checksum (8-bit sum of command and payload, length excluded) and
// the end marker. Each payload byte comes out at once as an rsp_ transaction
// with rsp_out_kind low; each frame closes with one verdict transaction
// (ok, no frame, short, bad end marker, bad checksum). Only the first frame
// of a buffer is parsed; the rest of that buffer is dropped. Parser state is
// registered and each result lands in a single output register, which accepts
// a new result in the same cycle the old one is taken, so a byte is taken
// every cycle as long as rsp_ready stays high; its result shows on rsp_ the
// cycle after. Markers are set through csr_ (index 0 start marker, index 1
// end marker) by the user only while the block is idle, which is not enforced.
module marker_frame_deframer_sum8 (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   // received bytes
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_buffer_end,
   // payload bytes and verdicts
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_out_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_payload_index,
   output logic [7:0] rsp_frame_cmd,
   output logic [7:0] rsp_frame_len,
   output logic [2:0] rsp_verdict
);
   import mfd_pkg::*;

   logic [ByteWidth-1:0] start_marker_ff;
   logic [ByteWidth-1:0] end_marker_ff;

   mfd_state_type  state_ff;
   mfd_state_type  state_in;
   mfd_result_type res;
   mfd_result_type rsp_data;
   logic           res_valid;
   logic           can_load;
   logic           req_take;

   // config writes are always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= StartMarkerReset;
         end_marker_ff   <= EndMarkerReset;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_data;
            CSR_END_MARKER:   end_marker_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // input is taken whenever the output register has room
   assign req_ready = can_load;
   assign req_take  = req_valid && can_load;

   mfd_parse u_parse (
      .state        (state_ff),
      .rx_byte      (req_rx_byte),
      .buffer_end   (req_buffer_end),
      .start_marker (start_marker_ff),
      .end_marker   (end_marker_ff),
      .state_in     (state_in),
      .res          (res),
      .res_valid    (res_valid)
   );

   // parser state: hunting, held fields cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= PH_HUNT;
         state_ff.cmd   <= '0;
         state_ff.len   <= '0;
         state_ff.idx   <= '0;
         state_ff.sum   <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   mfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_take && res_valid),
      .res       (res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .can_load  (can_load),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_kind      = rsp_data.kind;
   assign rsp_payload_byte  = rsp_data.pbyte;
   assign rsp_payload_index = rsp_data.pidx;
   assign rsp_frame_cmd     = rsp_data.cmd;
   assign rsp_frame_len     = rsp_data.len;
   assign rsp_verdict       = rsp_data.verdict;

endmodule

### bench/marker_frame_deframer_sum8_tb.sv
`timescale 1ns / 1ps

// Checks the marker-framed deframer against a cycle-free tracker of the frame
// parser. Every accepted req_ transaction is run through the tracker. Any
// payload byte or verdict it produces is queued, and each rsp_ transaction is
// checked field by field against the head of that queue.
module marker_frame_deframer_sum8_tb;
   import mfd_pkg::*;

   // index with no register behind it; a write there must change nothing
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE = 2'd2;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = CSR_START_MARKER;
   logic [ByteWidth-1:0]     csr_data  = '0;

   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [ByteWidth-1:0] req_rx_byte    = '0;
   logic                 req_buffer_end = 1'b0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_out_kind;
   logic [ByteWidth-1:0]    rsp_payload_byte;
   logic [ByteWidth-1:0]    rsp_payload_index;
   logic [ByteWidth-1:0]    rsp_frame_cmd;
   logic [ByteWidth-1:0]    rsp_frame_len;
   logic [VerdictWidth-1:0] rsp_verdict;

   // back-pressure knobs, percent of cycles spent idle on each side
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // tracker copy of the parser state and of the two marker registers
   logic [PhaseWidth-1:0] trk_phase = PH_HUNT;
   logic [ByteWidth-1:0]  trk_cmd   = '0;
   logic [ByteWidth-1:0]  trk_len   = '0;
   logic [8:0]            trk_count = '0;   // bytes after the marker
   logic [ByteWidth-1:0]  trk_sum   = '0;
   logic [ByteWidth-1:0]  cfg_start = StartMarkerReset;
   logic [ByteWidth-1:0]  cfg_end   = EndMarkerReset;

   mfd_result_type frame_events_due[$];   // payload bytes and verdicts not yet seen
   mfd_result_type want;
   int             mismatches   = 0;
   int             parsed_bytes = 0;      // bytes the parser actually acted on

   marker_frame_deframer_sum8 u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .req_buffer_end    (req_buffer_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_cmd     (rsp_frame_cmd),
      .rsp_frame_len     (rsp_frame_len),
      .rsp_verdict       (rsp_verdict)
   );

   always #5 clock = ~clock;

   // Advance the tracker by one received byte and queue whatever it emits.
   // A verdict only carries cmd/len once the length byte has been read;
   // "no frame" always reports zeros there.
   function automatic void deframe_byte(input logic [ByteWidth-1:0] b, input logic last);
      mfd_result_type        r;
      logic                  emit;
      logic [ByteWidth-1:0]  k;
      logic [PhaseWidth-1:0] was;
      r    = '0;
      emit = 1'b0;
      was  = trk_phase;
      case (trk_phase)
         PH_HUNT: begin
            if (b == cfg_start && !last) begin
               trk_phase = PH_CMD;
               trk_cmd   = '0;
               trk_len   = '0;
               trk_count = '0;
               trk_sum   = '0;
            end else if (last) begin
               emit      = 1'b1;
               r.kind    = KIND_VERDICT;
               r.verdict = V_NOFRAME;
            end
         end
         PH_CMD: begin
            trk_cmd   = b;
            trk_sum   = b;
            trk_count = 9'd1;
            trk_phase = last ? PH_HUNT : PH_LEN;
            if (last) begin
               emit      = 1'b1;
               r.kind    = KIND_VERDICT;
               r.verdict = V_NOFRAME;
            end
         end
         PH_LEN: begin
            trk_len   = b;
            trk_count = 9'd2;
            if (last) begin
               trk_phase = PH_HUNT;
               emit      = 1'b1;
               r.kind    = KIND_VERDICT;
               r.verdict = V_NOFRAME;
            end else begin
               trk_phase = (b != 8'd0) ? PH_PAY : PH_SUM;
            end
         end
         PH_PAY: begin
            emit = 1'b1;
            if (last) begin
               // payload byte that lands on the buffer end is dropped
               trk_phase = PH_HUNT;
               r.kind    = KIND_VERDICT;
               r.cmd     = trk_cmd;
               r.len     = trk_len;
               r.verdict = V_SHORT;
            end else begin
               k         = 8'(trk_count - 9'd2);
               r.kind    = KIND_PAYLOAD;
               r.pbyte   = b;
               r.pidx    = k;
               r.cmd     = trk_cmd;
               r.len     = trk_len;
               trk_sum   = trk_sum + b;
               trk_count = trk_count + 9'd1;
               if ({1'b0, k} + 9'd1 >= {1'b0, trk_len})
                  trk_phase = PH_SUM;
            end
         end
         PH_SUM: begin
            if (last) begin
               trk_phase = PH_HUNT;
               emit      = 1'b1;
               r.kind    = KIND_VERDICT;
               r.cmd     = trk_cmd;
               r.len     = trk_len;
               r.verdict = V_SHORT;
            end else begin
               trk_count = trk_count + 9'd1;
               trk_phase = (b == trk_sum) ? PH_END_OK : PH_END_BAD;
            end
         end
         PH_END_OK, PH_END_BAD: begin
            // end marker outranks the checksum
            emit   = 1'b1;
            r.kind = KIND_VERDICT;
            r.cmd  = trk_cmd;
            r.len  = trk_len;
            if (b != cfg_end)
               r.verdict = V_BADEND;
            else
               r.verdict = (trk_phase == PH_END_OK) ? V_OK : V_BADSUM;
            trk_count = trk_count + 9'd1;
            trk_phase = last ? PH_HUNT : PH_DONE;
         end
         default: begin
            if (last)
               trk_phase = PH_HUNT;
         end
      endcase
      if (emit)
         frame_events_due.push_back(r);
      if (emit || trk_phase != was || (was != PH_HUNT && was != PH_DONE))
         parsed_bytes++;
   endfunction

   // One req_ transaction. Called at a rising edge; valid stays high into the
   // next call unless that call decides to idle first.
   task automatic push_rx_byte(input logic [ByteWidth-1:0] value, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_rx_byte    <= value;
      req_buffer_end <= last;
      do @(posedge clock); while (!req_ready);
      deframe_byte(value, last);
   endtask

   // Stop sending, let every queued transaction drain, then a few spare cycles
   // for a byte that produced nothing but may still be in flight.
   task automatic drain_outputs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_events_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_marker(input logic [CsrIndexWidth-1:0] idx,
                               input logic [ByteWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_START_MARKER)
         cfg_start = value;
      else if (idx == CSR_END_MARKER)
         cfg_end = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // One receive buffer: optional noise, a frame built against the current
   // markers, optional trailing bytes. cut >= 0 ends the buffer on the byte
   // that sits cut positions after the start marker.
   task automatic send_buffer(input int noise, input logic [ByteWidth-1:0] cmd,
                              input logic [ByteWidth-1:0] len, input bit bad_sum,
                              input bit bad_end, input int cut, input int tail);
      logic [ByteWidth-1:0] stream[$];
      logic [ByteWidth-1:0] chk;
      logic [ByteWidth-1:0] b;
      int                   i;
      stream = {};
      for (i = 0; i < noise; i++) begin
         b = 8'($urandom);
         if (b == cfg_start)
            b = ~b;
         stream.push_back(b);
      end
      stream.push_back(cfg_start);
      stream.push_back(cmd);
      stream.push_back(len);
      chk = cmd;
      for (i = 0; i < int'(len); i++) begin
         b   = 8'($urandom);
         chk = chk + b;
         stream.push_back(b);
      end
      if (bad_sum)
         chk = chk + 8'($urandom_range(1, 255));
      stream.push_back(chk);
      stream.push_back(bad_end ? cfg_end + 8'($urandom_range(1, 255)) : cfg_end);
      for (i = 0; i < tail; i++)
         stream.push_back(8'($urandom));
      if (cut >= 0)
         while (stream.size() > noise + cut + 1)
            void'(stream.pop_back());
      for (i = 0; i < stream.size(); i++)
         push_rx_byte(stream[i], i == stream.size() - 1);
   endtask

   // Reset markers: every verdict, every place a buffer can run out, and the
   // start marker showing up where it must be taken as plain data.
   task automatic test_default_markers();
      send_idle_pct = 19;
      recv_idle_pct = 69;
      push_rx_byte(8'h00, 1'b1);             // buffer ends while hunting
      push_rx_byte(cfg_start, 1'b1);         // marker as the very last byte
      send_buffer(0, 8'h00, 8'd0, 0, 0, -1, 0);   // empty payload, ok
      send_buffer(3, 8'hFF, 8'd3, 0, 0, -1, 0);   // leading noise, ok
      send_buffer(0, 8'h5A, 8'd2, 0, 1, -1, 0);   // bad end marker
      send_buffer(0, 8'hA5, 8'd2, 1, 0, -1, 0);   // bad checksum
      send_buffer(0, 8'h01, 8'd1, 1, 1, -1, 0);   // both wrong: end wins
      send_buffer(0, 8'h80, 8'd4, 0, 0, 1, 0);    // runs out on cmd
      send_buffer(0, 8'h7F, 8'd4, 0, 0, 2, 0);    // runs out on length
      send_buffer(0, 8'h33, 8'd4, 0, 0, 4, 0);    // runs out mid payload
      send_buffer(0, 8'hC3, 8'd2, 0, 0, 5, 0);    // runs out on checksum
      send_buffer(1, 8'h3C, 8'd1, 0, 0, -1, 6);   // trailing junk ignored
      // marker value as cmd and payload, 0xFF payload, then a whole second
      // frame in the same buffer that must be ignored
      push_rx_byte(8'hAA, 1'b0);
      push_rx_byte(8'hAA, 1'b0);
      push_rx_byte(8'h02, 1'b0);
      push_rx_byte(8'hAA, 1'b0);
      push_rx_byte(8'hFF, 1'b0);
      push_rx_byte(8'h53, 1'b0);
      push_rx_byte(8'h55, 1'b0);
      push_rx_byte(8'hAA, 1'b0);
      push_rx_byte(8'h01, 1'b0);
      push_rx_byte(8'h00, 1'b0);
      push_rx_byte(8'h01, 1'b0);
      push_rx_byte(8'h55, 1'b1);
   endtask

   // Marker registers at their extremes, the spare index, and the longest frame.
   task automatic test_marker_registers();
      drain_outputs();
      write_marker(CSR_START_MARKER, 8'h00);
      write_marker(CSR_END_MARKER, 8'hFF);
      write_marker(CSR_SPARE, 8'($urandom));
      send_buffer(2, 8'hFF, 8'd255, 0, 0, -1, 0);
      send_buffer(1, 8'h00, 8'd1, 0, 1, -1, 2);
      push_rx_byte(8'hAA, 1'b1);             // old start marker means nothing now
      drain_outputs();
      write_marker(CSR_START_MARKER, 8'hFF);
      write_marker(CSR_END_MARKER, 8'h00);
      send_buffer(0, 8'h12, 8'd3, 1, 0, -1, 0);
      send_buffer(0, 8'h00, 8'd0, 0, 0, -1, 1);
   endtask

   // Random buffers, mostly well-formed frames with random content, the rest
   // truncated frames, corrupted frames and plain noise.
   task automatic test_random_buffers(input int send_pct, input int recv_pct,
                                      input logic [ByteWidth-1:0] start_mk,
                                      input logic [ByteWidth-1:0] end_mk,
                                      input int goal);
      int                   stop_at;
      int                   sel;
      int                   noise;
      int                   tail;
      int                   cut;
      int                   n;
      int                   i;
      logic [ByteWidth-1:0] len;
      drain_outputs();
      write_marker(CSR_START_MARKER, start_mk);
      write_marker(CSR_END_MARKER, end_mk);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = parsed_bytes + goal;
      while (parsed_bytes < stop_at) begin
         sel = $urandom_range(99);
         if (sel < 8) begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++)
               push_rx_byte(8'($urandom), i == n - 1);
         end else begin
            // long frames are rare so most traffic stays short
            if ($urandom_range(79) == 0)
               len = 8'($urandom_range(9, 255));
            else
               len = 8'($urandom_range(0, 8));
            noise = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
            tail  = ($urandom_range(4) == 0) ? $urandom_range(1, 5) : 0;
            cut   = (sel < 25) ? $urandom_range(0, int'(len) + 4) : -1;
            send_buffer(noise, 8'($urandom), len, $urandom_range(9) == 0,
                        $urandom_range(9) == 0, cut, tail);
         end
      end
   endtask

   // Receiver: random back-pressure, and the field-by-field comparison of each
   // rsp_ transaction against the oldest queued expectation.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_events_due.size() == 0) begin
            $error("unexpected rsp transaction: kind %0d byte %0h verdict %0d",
                   rsp_out_kind, rsp_payload_byte, rsp_verdict);
            mismatches++;
         end else begin
            want = frame_events_due.pop_front();
            if (rsp_out_kind !== want.kind) begin
               $error("out_kind: expected %0d, got %0d", want.kind, rsp_out_kind);
               mismatches++;
            end
            if (rsp_payload_byte !== want.pbyte) begin
               $error("payload_byte: expected %0h, got %0h", want.pbyte, rsp_payload_byte);
               mismatches++;
            end
            if (rsp_payload_index !== want.pidx) begin
               $error("payload_index: expected %0d, got %0d", want.pidx, rsp_payload_index);
               mismatches++;
            end
            if (rsp_frame_cmd !== want.cmd) begin
               $error("frame_cmd: expected %0h, got %0h", want.cmd, rsp_frame_cmd);
               mismatches++;
            end
            if (rsp_frame_len !== want.len) begin
               $error("frame_len: expected %0d, got %0d", want.len, rsp_frame_len);
               mismatches++;
            end
            if (rsp_verdict !== want.verdict) begin
               $error("verdict: expected %0d, got %0d", want.verdict, rsp_verdict);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_markers();
      test_marker_registers();
      test_random_buffers(19, 69, 8'h00, 8'hFF, 360);
      test_random_buffers(69, 19, 8'hFF, 8'h00, 360);
      // equal markers, no idling on either side
      test_random_buffers(0, 0, 8'h3C, 8'h3C, 360);
      drain_outputs();
      if (mismatches == 0 && frame_events_due.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // hang guard: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
